FILE: sv/pscl_pkg.sv
`timescale 1ns / 1ps
package pscl_pkg;

  localparam int unsigned CNT_W = 7;
  localparam int unsigned PID_W = 23;
  localparam int unsigned UID_W = 32;
  localparam int unsigned IDX_W = 2;

  // result status codes
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_REFUSED   = 2'd1;
  localparam logic [1:0] STATUS_UNTRACKED = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MAX_CONN = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_PROC = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_USER = 2'd2;

  typedef struct packed {
    logic             action;
    logic [PID_W-1:0] process_id;
    logic [UID_W-1:0] user_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] open_total;
  } out_item_t;

  // sequencer -> table
  typedef struct packed {
    logic clear;  // clearing pass write at addr
    logic first;  // new transaction: drop search results
    logic rd_en;  // read issued at addr
    logic upd;    // commit count/key to selected slot
  } tbl_ctl_t;

  // table -> sequencer
  typedef struct packed {
    logic             hit;      // key tracked
    logic             slot_ok;  // hit or free slot found
    logic [CNT_W-1:0] cnt;      // count of hit entry, zero if none
  } tbl_sts_t;

endpackage

FILE: sv/pscl_ram.sv
`timescale 1ns / 1ps
module pscl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/pscl_table.sv
`timescale 1ns / 1ps
module pscl_table #(
  parameter int KEY_W   = 23,
  parameter int ENTRIES = 64
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  pscl_pkg::tbl_ctl_t                       ctl_i,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] addr_i,
  input  logic [KEY_W-1:0]                         key_i,
  input  logic [pscl_pkg::CNT_W-1:0]               cnt_wr_i,
  output pscl_pkg::tbl_sts_t                       sts_o
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [KEY_W-1:0]           key_rd;
  logic [pscl_pkg::CNT_W-1:0] cnt_rd;
  logic                       cmp_vld_q;
  logic [AW-1:0]              cmp_idx_q;
  logic                       hit_q, free_q;
  logic [AW-1:0]              hit_slot_q, free_slot_q;
  logic [pscl_pkg::CNT_W-1:0] hit_cnt_q;
  logic [AW-1:0]              tgt_slot;
  logic                       cnt_we;
  logic [AW-1:0]              cnt_waddr;
  logic [pscl_pkg::CNT_W-1:0] cnt_wdata;
  logic                       match, empty;

  assign tgt_slot  = hit_q ? hit_slot_q : free_slot_q;
  assign cnt_we    = ctl_i.clear | ctl_i.upd;
  assign cnt_waddr = ctl_i.clear ? addr_i : tgt_slot;
  assign cnt_wdata = ctl_i.clear ? '0 : cnt_wr_i;

  pscl_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_keys (
    .clk_i  (clk_i),
    .we_i   (ctl_i.upd),
    .waddr_i(tgt_slot),
    .wdata_i(key_i),
    .raddr_i(addr_i),
    .rdata_o(key_rd)
  );

  pscl_ram #(.WIDTH(pscl_pkg::CNT_W), .DEPTH(ENTRIES)) u_counts (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .raddr_i(addr_i),
    .rdata_o(cnt_rd)
  );

  // shared compare: one entry per cycle, lowest index wins
  assign empty = (cnt_rd == '0);
  assign match = !empty && (key_rd == key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      cmp_vld_q <= ctl_i.rd_en;
      if (ctl_i.first) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (cmp_vld_q) begin
        if (match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (empty && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= addr_i;
    if (ctl_i.first) begin
      hit_cnt_q <= '0;
    end else if (cmp_vld_q) begin
      if (match && !hit_q) begin
        hit_slot_q <= cmp_idx_q;
        hit_cnt_q  <= cnt_rd;
      end
      if (empty && !free_q) begin
        free_slot_q <= cmp_idx_q;
      end
    end
  end

  assign sts_o.hit     = hit_q;
  assign sts_o.slot_ok = hit_q | free_q;
  assign sts_o.cnt     = hit_cnt_q;

endmodule

FILE: sv/per_source_connection_limiter.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in        input      in_valid_i/in_stall_o    in_data_i  (action, process_id, user_id)
// out       output     out_valid_o/out_stall_i  out_data_o (status, open_total)
// cfg       input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// Search: each transaction scans every entry of the key/count RAMs, one entry per cycle,
//   through one shared compare per table; no new transaction is taken until it is decided.
// Reset: after rst_ni rises, a clearing pass zeroes every entry of both count RAMs;
//   in_stall_o stays high meanwhile. Config writes are always taken.
// Stalls: the result sits in an output register; the decide step waits while a
//   previous result is still held by out_stall_i.
module per_source_connection_limiter #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  pscl_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output pscl_pkg::out_item_t              out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pscl_pkg::IDX_W-1:0]       cfg_index_i,
  input  logic [pscl_pkg::CNT_W-1:0]       cfg_data_i
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_DECIDE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0]              addr_q, addr_d;
  logic [pscl_pkg::CNT_W-1:0] total_q, total_d;
  logic [pscl_pkg::CNT_W-1:0] max_conn_q, max_proc_q, max_user_q;
  pscl_pkg::in_item_t         item_q;
  logic                       out_valid_q;
  pscl_pkg::out_item_t        out_q;

  pscl_pkg::tbl_ctl_t         ctl;
  pscl_pkg::tbl_sts_t         p_sts, u_sts;
  logic                       in_acc, out_free, commit, upd_ok;
  logic [1:0]                 status;
  logic [pscl_pkg::CNT_W-1:0] p_new, u_new, total_next;
  logic                       refuse;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign cfg_ready_o = 1'b1;

  // ---- config registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_conn_q <= 7'd64;
      max_proc_q <= 7'd64;
      max_user_q <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pscl_pkg::REG_MAX_CONN: max_conn_q <= cfg_data_i;
        pscl_pkg::REG_MAX_PROC: max_proc_q <= cfg_data_i;
        pscl_pkg::REG_MAX_USER: max_user_q <= cfg_data_i;
        default: ;  // unused index: ignored
      endcase
    end
  end

  // ---- table units ----
  assign ctl.clear = (state_q == ST_CLEAR);
  assign ctl.first = in_acc;
  assign ctl.rd_en = (state_q == ST_SCAN);
  assign ctl.upd   = commit;

  pscl_table #(.KEY_W(pscl_pkg::PID_W), .ENTRIES(TABLE_ENTRIES)) u_proc_tbl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .addr_i  (addr_q),
    .key_i   (item_q.process_id),
    .cnt_wr_i(p_new),
    .sts_o   (p_sts)
  );

  pscl_table #(.KEY_W(pscl_pkg::UID_W), .ENTRIES(TABLE_ENTRIES)) u_user_tbl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .addr_i  (addr_q),
    .key_i   (item_q.user_id),
    .cnt_wr_i(u_new),
    .sts_o   (u_sts)
  );

  // ---- decide: admission check or close on the finished search ----
  // Counts of untracked keys read as zero, so an open uses them directly.
  always_comb begin
    refuse     = (total_q >= max_conn_q) || (p_sts.cnt >= max_proc_q) ||
                 (u_sts.cnt >= max_user_q) || !p_sts.slot_ok || !u_sts.slot_ok;
    total_next = total_q;
    if (item_q.action) begin
      upd_ok = p_sts.hit & u_sts.hit;
      status = upd_ok ? pscl_pkg::STATUS_DONE : pscl_pkg::STATUS_UNTRACKED;
      p_new  = p_sts.cnt - 7'd1;
      u_new  = u_sts.cnt - 7'd1;
      if (upd_ok && total_q != '0) begin
        total_next = total_q - 7'd1;  // never below zero
      end
    end else begin
      upd_ok = ~refuse;
      status = refuse ? pscl_pkg::STATUS_REFUSED : pscl_pkg::STATUS_DONE;
      p_new  = p_sts.cnt + 7'd1;
      u_new  = u_sts.cnt + 7'd1;
      if (upd_ok) begin
        total_next = total_q + 7'd1;
      end
    end
  end

  assign commit = (state_q == ST_DECIDE) && out_free && upd_ok;

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    total_d = total_q;
    case (state_q)
      ST_CLEAR: begin
        addr_d = addr_q + AW'(1);
        if (addr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
          addr_d  = '0;
        end
      end
      ST_IDLE: begin
        addr_d = '0;
        if (in_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        addr_d = addr_q + AW'(1);
        if (addr_q == LAST_ADDR) begin
          state_d = ST_DRAIN;
          addr_d  = '0;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;  // last compare lands this cycle
      end
      ST_DECIDE: begin
        if (out_free) begin
          total_d = total_next;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      total_q <= total_d;
      if ((state_q == ST_DECIDE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    if ((state_q == ST_DECIDE) && out_free) begin
      out_q.status     <= status;
      out_q.open_total <= total_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a result only appears right after a decide step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DECIDE))
    else $error("result raised outside decide");

  // an admitted open adds exactly one to the total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && !item_q.action) |=> (total_q == $past(total_q) + 7'd1))
    else $error("admitted open did not bump total");

  // a refused or untracked transaction leaves the total alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DECIDE) && out_free && !upd_ok) |=> $stable(total_q))
    else $error("rejected transaction changed total");

  // tables are only written in the decide step, apart from the clearing pass on the count RAMs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.upd |-> (state_q == ST_DECIDE) && !ctl.clear)
    else $error("table update outside decide");
`endif

endmodule
